@@ hdl/stq_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stq_pkg
// Shared types, constants and codes of the sorted timeout queue.
// ----------------------------------------------------------------------------
package stq_pkg;

  localparam int Entries = 16;
  localparam int IdxW = $clog2(Entries);
  localparam int CntW = $clog2(Entries + 1);
  localparam logic [19:0] UsecPerSec = 20'd1000000;
  localparam logic [19:0] UsecMax = 20'd999999;

  typedef enum logic [2:0] {
    OP_INSERT   = 3'd0,
    OP_REMOVE   = 3'd1,
    OP_RESCAN   = 3'd2,
    OP_EXPIRED  = 3'd3,
    OP_EARLIEST = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_BUSY   = 2'd1,
    ST_ABSENT = 2'd2,
    ST_NONE   = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_INS_SCAN,
    S_INS_SHIFT,
    S_REM_SCAN,
    S_REM_SHIFT,
    S_RSC_READ,
    S_RSC_CALC,
    S_EXP_READ,
    S_EXP_TEST,
    S_EARLY_READ,
    S_EARLY_EMIT,
    S_DONE
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic load;       // capture input item
    logic clr_idx;    // index := 0
    logic inc_idx;    // index += 1
    logic set_pos;    // pos := index, index := count
    logic pos_end;    // pos := count, index := count
    logic ins_write;  // write slot tables for new timer
    logic shift_up;   // order[index] := order[index-1], index -= 1
    logic put_new;    // order[pos] := handle, valid, count += 1
    logic shift_dn;   // order[pos] := order[pos+1], pos += 1
    logic rem_done;   // drop valid, count -= 1 if pos < count
    logic rd_slot;    // register slot fields of order[index]
    logic rsc_wr;     // write recomputed time left, count expired
    logic clr_exp;
    logic emit_slot;  // result from registered slot
    logic emit_stat;  // result with status only
    logic emit_cnt;   // result with expired count
    status_e stat;
  } stq_cmd_t;

  // datapath to controller
  typedef struct packed {
    op_e      op;
    logic     h_valid;
    logic     h_busy;
    logic     full;
    logic     inf;
    logic     idx_at_end;   // index == count
    logic     idx_gt_pos;
    logic     pos_ge_end;   // pos + 1 >= count
    logic     empty;
    logic     match_ins;    // scanned slot sorts after new timer
    logic     match_rem;    // order[index] == handle
    logic     slot_exp;
  } stq_sts_t;

  function automatic logic [19:0] clamp_usec(logic [19:0] v);
    return (v > UsecMax) ? UsecMax : v;
  endfunction

endpackage

@@ hdl/stq_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stq_in_if / stq_out_if
// Valid/ready channels carrying the queue's request and result items.
// ----------------------------------------------------------------------------
interface stq_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  operation;
  logic [3:0]  handle;
  logic [30:0] timeout_sec;
  logic [19:0] timeout_usec;
  logic        infinite;
  logic [31:0] now_sec;
  logic [19:0] now_usec;
  modport source (output valid, operation, handle, timeout_sec, timeout_usec,
                  infinite, now_sec, now_usec, input ready);
  modport sink (input valid, operation, handle, timeout_sec, timeout_usec,
                infinite, now_sec, now_usec, output ready);
endinterface

interface stq_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic [3:0]         found_handle;
  logic [4:0]         expired_count;
  logic signed [32:0] left_sec;
  logic [19:0]        left_usec;
  modport source (output valid, status, found_handle, expired_count, left_sec,
                  left_usec, input ready);
  modport sink (input valid, status, found_handle, expired_count, left_sec,
                left_usec, output ready);
endinterface

@@ hdl/stq_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stq_ctrl
// Sequencer for insert, remove, rescan and the two lookups.
// ----------------------------------------------------------------------------
module stq_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               res_free_i,
  input  stq_pkg::stq_sts_t  sts_i,
  output stq_pkg::stq_cmd_t  cmd_o
);

  stq_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= stq_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o = (state_q == stq_pkg::S_IDLE);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      stq_pkg::S_IDLE: begin
        // decode happens on the registered item
        if (in_valid_i) state_d = stq_pkg::S_EARLY_READ;
      end
      stq_pkg::S_EARLY_READ: begin
        unique case (sts_i.op)
          stq_pkg::OP_INSERT: begin
            if (!sts_i.h_valid || sts_i.h_busy || sts_i.full) state_d = stq_pkg::S_DONE;
            else if (sts_i.inf) state_d = stq_pkg::S_INS_SHIFT;
            else state_d = stq_pkg::S_INS_SCAN;
          end
          stq_pkg::OP_REMOVE: begin
            if (!sts_i.h_valid || !sts_i.h_busy) state_d = stq_pkg::S_DONE;
            else state_d = stq_pkg::S_REM_SCAN;
          end
          stq_pkg::OP_RESCAN: state_d = stq_pkg::S_RSC_READ;
          stq_pkg::OP_EXPIRED: state_d = stq_pkg::S_EXP_READ;
          stq_pkg::OP_EARLIEST: begin
            if (sts_i.empty) state_d = stq_pkg::S_DONE;
            else state_d = stq_pkg::S_EARLY_EMIT;
          end
          default: state_d = stq_pkg::S_DONE;
        endcase
      end
      stq_pkg::S_INS_SCAN: begin
        if (sts_i.idx_at_end || sts_i.match_ins) state_d = stq_pkg::S_INS_SHIFT;
      end
      stq_pkg::S_INS_SHIFT: begin
        if (!sts_i.idx_gt_pos) state_d = stq_pkg::S_DONE;
      end
      stq_pkg::S_REM_SCAN: begin
        if (sts_i.idx_at_end || sts_i.match_rem) state_d = stq_pkg::S_REM_SHIFT;
      end
      stq_pkg::S_REM_SHIFT: begin
        if (sts_i.pos_ge_end) state_d = stq_pkg::S_DONE;
      end
      stq_pkg::S_RSC_READ: begin
        if (sts_i.idx_at_end) state_d = stq_pkg::S_DONE;
        else state_d = stq_pkg::S_RSC_CALC;
      end
      stq_pkg::S_RSC_CALC: state_d = stq_pkg::S_RSC_READ;
      stq_pkg::S_EXP_READ: begin
        if (sts_i.idx_at_end) state_d = stq_pkg::S_DONE;
        else state_d = stq_pkg::S_EXP_TEST;
      end
      stq_pkg::S_EXP_TEST: begin
        if (sts_i.slot_exp) state_d = stq_pkg::S_DONE;
        else state_d = stq_pkg::S_EXP_READ;
      end
      stq_pkg::S_EARLY_EMIT: state_d = stq_pkg::S_DONE;
      stq_pkg::S_DONE: begin
        if (res_free_i) state_d = stq_pkg::S_IDLE;
      end
      default: state_d = stq_pkg::S_IDLE;
    endcase
  end

  // S_DONE holds until the item's result has left the result register
  always_comb begin
    cmd_o = '0;
    cmd_o.stat = stq_pkg::ST_OK;
    unique case (state_q)
      stq_pkg::S_IDLE: begin
        cmd_o.load = in_valid_i;
        cmd_o.clr_idx = in_valid_i;
      end
      stq_pkg::S_EARLY_READ: begin
        cmd_o.rd_slot = 1'b1;
        cmd_o.clr_exp = 1'b1;
        unique case (sts_i.op)
          stq_pkg::OP_INSERT: begin
            if (!sts_i.h_valid) begin
              cmd_o.emit_stat = 1'b1;
              cmd_o.stat = stq_pkg::ST_ABSENT;
            end else if (sts_i.h_busy || sts_i.full) begin
              cmd_o.emit_stat = 1'b1;
              cmd_o.stat = stq_pkg::ST_BUSY;
            end else begin
              cmd_o.ins_write = 1'b1;
              if (sts_i.inf) cmd_o.pos_end = 1'b1;
            end
          end
          stq_pkg::OP_REMOVE: begin
            if (!sts_i.h_valid || !sts_i.h_busy) begin
              cmd_o.emit_stat = 1'b1;
              cmd_o.stat = stq_pkg::ST_ABSENT;
            end
          end
          stq_pkg::OP_RESCAN, stq_pkg::OP_EXPIRED: ;
          stq_pkg::OP_EARLIEST: begin
            if (sts_i.empty) begin
              cmd_o.emit_stat = 1'b1;
              cmd_o.stat = stq_pkg::ST_NONE;
            end
          end
          default: cmd_o.emit_stat = 1'b1;
        endcase
      end
      stq_pkg::S_INS_SCAN: begin
        if (sts_i.idx_at_end || sts_i.match_ins) cmd_o.set_pos = 1'b1;
        else cmd_o.inc_idx = 1'b1;
      end
      stq_pkg::S_INS_SHIFT: begin
        if (sts_i.idx_gt_pos) cmd_o.shift_up = 1'b1;
        else begin
          cmd_o.put_new = 1'b1;
          cmd_o.emit_stat = 1'b1;
        end
      end
      stq_pkg::S_REM_SCAN: begin
        if (sts_i.idx_at_end || sts_i.match_rem) cmd_o.set_pos = 1'b1;
        else cmd_o.inc_idx = 1'b1;
      end
      stq_pkg::S_REM_SHIFT: begin
        if (sts_i.pos_ge_end) begin
          cmd_o.rem_done = 1'b1;
          cmd_o.emit_stat = 1'b1;
        end else cmd_o.shift_dn = 1'b1;
      end
      stq_pkg::S_RSC_READ: begin
        if (sts_i.idx_at_end) cmd_o.emit_cnt = 1'b1;
        else cmd_o.rd_slot = 1'b1;
      end
      stq_pkg::S_RSC_CALC: begin
        cmd_o.rsc_wr = 1'b1;
        cmd_o.inc_idx = 1'b1;
      end
      stq_pkg::S_EXP_READ: begin
        if (sts_i.idx_at_end) begin
          cmd_o.emit_stat = 1'b1;
          cmd_o.stat = stq_pkg::ST_NONE;
        end else cmd_o.rd_slot = 1'b1;
      end
      stq_pkg::S_EXP_TEST: begin
        if (sts_i.slot_exp) cmd_o.emit_slot = 1'b1;
        else cmd_o.inc_idx = 1'b1;
      end
      stq_pkg::S_EARLY_EMIT: cmd_o.emit_slot = 1'b1;
      stq_pkg::S_DONE: ;
      default: ;
    endcase
  end

endmodule

@@ hdl/stq_datapath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stq_datapath
// Slot tables, order list, scan index and result register.
// ----------------------------------------------------------------------------
module stq_datapath (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic [2:0]                     operation_i,
  input  logic [3:0]                     handle_i,
  input  logic [30:0]                    timeout_sec_i,
  input  logic [19:0]                    timeout_usec_i,
  input  logic                           infinite_i,
  input  logic [31:0]                    now_sec_i,
  input  logic [19:0]                    now_usec_i,
  input  stq_pkg::stq_cmd_t              cmd_i,
  output stq_pkg::stq_sts_t              sts_o,
  output logic                           res_free_o,
  output logic                           res_valid_o,
  input  logic                           res_ready_i,
  output logic [1:0]                     status_o,
  output logic [3:0]                     found_handle_o,
  output logic [4:0]                     expired_count_o,
  output logic signed [32:0]             left_sec_o,
  output logic [19:0]                    left_usec_o
);

  localparam int IdxW = stq_pkg::IdxW;
  localparam int CntW = stq_pkg::CntW;
  localparam int N = stq_pkg::Entries;

  // captured item
  logic [2:0]  op_q;
  logic [3:0]  h_q;
  logic [30:0] tsec_q;
  logic [19:0] tusec_q;
  logic        inf_q;
  logic [31:0] nsec_q;
  logic [19:0] nusec_q;

  logic [N-1:0]       valid_q;
  logic [N-1:0]       inf_tab_q;
  logic [32:0]        dl_sec_q [N];
  logic [19:0]        dl_usec_q [N];
  logic signed [33:0] rem_sec_q [N];
  logic [19:0]        rem_usec_q [N];
  logic [IdxW-1:0]    order_q [N];
  logic [CntW-1:0]    count_q;
  logic [CntW-1:0]    idx_q;
  logic [CntW-1:0]    pos_q;
  logic [CntW-1:0]    exp_q;

  // registered slot under test
  logic [IdxW-1:0]    sl_h_q;
  logic               sl_inf_q;
  logic signed [33:0] sl_sec_q;
  logic [19:0]        sl_usec_q;
  logic [32:0]        sl_dsec_q;
  logic [19:0]        sl_dusec_q;

  logic               rv_q;
  logic [1:0]         rs_q;
  logic [3:0]         rh_q;
  logic [4:0]         rc_q;
  logic signed [32:0] rls_q;
  logic [19:0]        rlu_q;

  logic [IdxW-1:0] hi;
  logic [IdxW-1:0] cur;
  logic [IdxW-1:0] idx_i;
  logic            h_ok;
  logic signed [33:0] tsec_x;
  logic            ins_less;
  logic [20:0]     du_sum;
  logic [33:0]     ds_sum;
  logic signed [34:0] rs_new;
  logic [20:0]     ru_tmp;
  logic [19:0]     ru_new;
  logic            new_exp;
  logic signed [33:0] sat_sec;

  assign h_ok = ({1'b0, h_q} < 5'(N));
  assign hi = IdxW'(h_q);
  assign idx_i = idx_q[IdxW-1:0];
  assign cur = order_q[idx_i];
  assign tsec_x = 34'(tsec_q);
  assign ins_less = inf_tab_q[cur] || (tsec_x < rem_sec_q[cur]) ||
                    ((tsec_x == rem_sec_q[cur]) && (tusec_q < rem_usec_q[cur]));

  assign du_sum = {1'b0, nusec_q} + {1'b0, tusec_q};
  assign ds_sum = 34'(nsec_q) + 34'(tsec_q);

  always_comb begin
    if (nusec_q > sl_dusec_q) begin
      ru_tmp = {1'b0, sl_dusec_q} + 21'(stq_pkg::UsecPerSec) - {1'b0, nusec_q};
      rs_new = 35'(sl_dsec_q) - 35'sd1 - 35'(nsec_q);
    end else begin
      ru_tmp = {1'b0, sl_dusec_q} - {1'b0, nusec_q};
      rs_new = 35'(sl_dsec_q) - 35'(nsec_q);
    end
    ru_new = ru_tmp[19:0];
    new_exp = (rs_new < 0) || (rs_new == 0 && ru_new == 20'd0);
  end

  always_comb begin
    sat_sec = sl_sec_q;
    if (sl_sec_q < -34'sd4294967296) sat_sec = -34'sd4294967296;
    if (sl_sec_q > 34'sd4294967295) sat_sec = 34'sd4294967295;
  end

  always_comb begin
    sts_o.op = stq_pkg::op_e'(op_q);
    sts_o.h_valid = h_ok;
    sts_o.h_busy = valid_q[hi];
    sts_o.full = (count_q >= CntW'(N));
    sts_o.inf = inf_q;
    sts_o.idx_at_end = (idx_q == count_q);
    sts_o.idx_gt_pos = (idx_q > pos_q);
    sts_o.pos_ge_end = ((pos_q + 1'b1) >= count_q);
    sts_o.empty = (count_q == '0);
    sts_o.match_ins = ins_less;
    sts_o.match_rem = (cur == hi);
    sts_o.slot_exp = !sl_inf_q &&
                     ((sl_sec_q < 0) || (sl_sec_q == 0 && sl_usec_q == 20'd0));
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q <= operation_i;
      h_q <= handle_i;
      tsec_q <= timeout_sec_i;
      tusec_q <= stq_pkg::clamp_usec(timeout_usec_i);
      inf_q <= infinite_i;
      nsec_q <= now_sec_i;
      nusec_q <= stq_pkg::clamp_usec(now_usec_i);
    end
    if (cmd_i.rd_slot) begin
      sl_h_q <= cur;
      sl_inf_q <= inf_tab_q[cur];
      sl_sec_q <= rem_sec_q[cur];
      sl_usec_q <= rem_usec_q[cur];
      sl_dsec_q <= dl_sec_q[cur];
      sl_dusec_q <= dl_usec_q[cur];
    end
    if (cmd_i.ins_write) begin
      rem_sec_q[hi] <= tsec_x;
      rem_usec_q[hi] <= tusec_q;
      inf_tab_q[hi] <= inf_q;
      if (du_sum >= 21'(stq_pkg::UsecPerSec)) begin
        dl_usec_q[hi] <= 20'(du_sum - 21'(stq_pkg::UsecPerSec));
        dl_sec_q[hi] <= 33'(ds_sum + 34'd1);
      end else begin
        dl_usec_q[hi] <= du_sum[19:0];
        dl_sec_q[hi] <= ds_sum[32:0];
      end
    end
    if (cmd_i.rsc_wr && !sl_inf_q) begin
      rem_sec_q[sl_h_q] <= rs_new[33:0];
      rem_usec_q[sl_h_q] <= ru_new;
    end
    if (cmd_i.shift_up) order_q[idx_i] <= order_q[IdxW'(idx_q - 1'b1)];
    if (cmd_i.shift_dn) order_q[pos_q[IdxW-1:0]] <= order_q[IdxW'(pos_q + 1'b1)];
    if (cmd_i.put_new) order_q[pos_q[IdxW-1:0]] <= hi;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      count_q <= '0;
      idx_q <= '0;
      pos_q <= '0;
      exp_q <= '0;
      rv_q <= 1'b0;
    end else begin
      if (cmd_i.clr_idx) idx_q <= '0;
      if (cmd_i.inc_idx) idx_q <= idx_q + 1'b1;
      if (cmd_i.shift_up) idx_q <= idx_q - 1'b1;
      if (cmd_i.set_pos) begin
        pos_q <= idx_q;
        idx_q <= count_q;
      end
      if (cmd_i.pos_end) begin
        pos_q <= count_q;
        idx_q <= count_q;
      end
      if (cmd_i.shift_dn) pos_q <= pos_q + 1'b1;
      if (cmd_i.put_new) begin
        valid_q[hi] <= 1'b1;
        count_q <= count_q + 1'b1;
      end
      if (cmd_i.rem_done) begin
        valid_q[hi] <= 1'b0;
        if (pos_q < count_q) count_q <= count_q - 1'b1;
      end
      if (cmd_i.clr_exp) exp_q <= '0;
      if (cmd_i.rsc_wr && !sl_inf_q && new_exp) exp_q <= exp_q + 1'b1;
      if (rv_q && res_ready_i) rv_q <= 1'b0;
      if (cmd_i.emit_slot || cmd_i.emit_stat || cmd_i.emit_cnt) rv_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_stat) begin
      rs_q <= cmd_i.stat;
      rh_q <= '0;
      rc_q <= '0;
      rls_q <= '0;
      rlu_q <= '0;
    end
    if (cmd_i.emit_cnt) begin
      rs_q <= stq_pkg::ST_OK;
      rh_q <= '0;
      rc_q <= 5'(exp_q);
      rls_q <= '0;
      rlu_q <= '0;
    end
    if (cmd_i.emit_slot) begin
      rs_q <= stq_pkg::ST_OK;
      rh_q <= 4'(sl_h_q);
      rc_q <= '0;
      rls_q <= sat_sec[32:0];
      rlu_q <= sl_usec_q;
    end
  end

  assign res_free_o = !rv_q || res_ready_i;
  assign res_valid_o = rv_q;
  assign status_o = rs_q;
  assign found_handle_o = rh_q;
  assign expired_count_o = rc_q;
  assign left_sec_o = rls_q;
  assign left_usec_o = rlu_q;

endmodule

@@ hdl/sorted_timeout_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_timeout_queue
// Sorted timer table with insert, remove, rescan and lookups.
// ----------------------------------------------------------------------------
// Rescan and expired search walk the order list entry by entry. One item
// at a time: the next item is taken only after the result of the last one
// has been accepted, so result stalls hold back the next item. Reset clears
// the valid bits and the entry count at once.
module sorted_timeout_queue (
  input  logic     clk_i,
  input  logic     rst_ni,
  stq_in_if.sink   in_i,
  stq_out_if.source out_o
);

  stq_pkg::stq_cmd_t cmd;
  stq_pkg::stq_sts_t sts;
  logic res_free;

  stq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .res_free_i (res_free),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  stq_datapath u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .operation_i     (in_i.operation),
    .handle_i        (in_i.handle),
    .timeout_sec_i   (in_i.timeout_sec),
    .timeout_usec_i  (in_i.timeout_usec),
    .infinite_i      (in_i.infinite),
    .now_sec_i       (in_i.now_sec),
    .now_usec_i      (in_i.now_usec),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .res_free_o      (res_free),
    .res_valid_o     (out_o.valid),
    .res_ready_i     (out_o.ready),
    .status_o        (out_o.status),
    .found_handle_o  (out_o.found_handle),
    .expired_count_o (out_o.expired_count),
    .left_sec_o      (out_o.left_sec),
    .left_usec_o     (out_o.left_usec)
  );

endmodule

@@ hdl/stq_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stq_checker
// Port-level checks of the sorted timeout queue.
// ----------------------------------------------------------------------------
module stq_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [1:0]  status_i,
  input logic [4:0]  expired_count_i,
  input logic [3:0]  found_handle_i
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(status_i))
    else $error("result dropped while stalled");

  a_no_take_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("item taken while busy");

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> expired_count_i <= 5'd16)
    else $error("expired count out of range");

  a_none_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && status_i == 2'd3 |-> found_handle_i == 4'd0)
    else $error("nothing found carries a handle");

endmodule

bind sorted_timeout_queue stq_checker u_stq_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_i.valid),
  .in_ready_i      (in_i.ready),
  .out_valid_i     (out_o.valid),
  .out_ready_i     (out_o.ready),
  .status_i        (out_o.status),
  .expired_count_i (out_o.expired_count),
  .found_handle_i  (out_o.found_handle)
);
